>>> rtl/multi_agent_pid_velocity_controller_top_defines.svh
// Assertion macros for the velocity controller.
`ifndef MULTI_AGENT_PID_VELOCITY_CONTROLLER_TOP_DEFINES_SVH
`define MULTI_AGENT_PID_VELOCITY_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MAPVC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mapvc assertion failed");
`define MAPVC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mapvc assertion failed");
`else
`define MAPVC_ASSERT_IMP(lbl, ante, cons)
`define MAPVC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/mapvc_pkg.sv
package mapvc_pkg;

  localparam int CW = 37;
  localparam int ZW = 32;
  localparam int MW = 33;
  localparam int PW = 66;

  localparam logic signed [MW-1:0] KINV_Q30 = 33'sd652032874;
  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314856;
  localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam int READY_THRESH = 3277;

  localparam logic [2:0] REG_AGENT_COUNT = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;

  localparam logic ACT_GOAL = 1'b0;
  localparam logic ACT_POS = 1'b1;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] k);
    logic signed [ZW-1:0] v;
    case (k)
      5'd0: v = 32'sd210828714;
      5'd1: v = 32'sd124459457;
      5'd2: v = 32'sd65760959;
      5'd3: v = 32'sd33381290;
      5'd4: v = 32'sd16755422;
      5'd5: v = 32'sd8385879;
      5'd6: v = 32'sd4193963;
      5'd7: v = 32'sd2097109;
      5'd8: v = 32'sd1048571;
      5'd9: v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/mapvc_ifs.sv
interface mapvc_cmd_if;
  logic valid;
  logic ready;
  logic action;
  logic [1:0] agent;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  modport source(output valid, action, agent, x_coord, y_coord, input ready);
  modport sink(input valid, action, agent, x_coord, y_coord, output ready);
endinterface

interface mapvc_res_if;
  logic valid;
  logic ready;
  logic [1:0] agent_out;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic vel_valid;
  logic ready_res;
  logic last;
  modport source(output valid, agent_out, vel_x, vel_y, vel_valid, ready_res, last,
                 input ready);
  modport sink(input valid, agent_out, vel_x, vel_y, vel_valid, ready_res, last,
               output ready);
endinterface

interface mapvc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] reg_index;
  logic [31:0] data;
  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

>>> rtl/mapvc_mul.sv
module mapvc_mul (
  input  logic clk,
  input  logic signed [mapvc_pkg::MW-1:0] a,
  input  logic signed [mapvc_pkg::MW-1:0] b,
  output logic signed [mapvc_pkg::PW-1:0] p
);
  import mapvc_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/mapvc_cordic.sv
module mapvc_cordic #(
  parameter int ITERS = 16
) (
  input  logic clk,
  input  logic rst,
  input  mapvc_pkg::cordic_ctl_t ctl,
  input  logic signed [mapvc_pkg::CW-1:0] x_in,
  input  logic signed [mapvc_pkg::CW-1:0] y_in,
  input  logic signed [mapvc_pkg::ZW-1:0] z_in,
  output mapvc_pkg::cordic_sts_t sts,
  output logic signed [mapvc_pkg::CW-1:0] x,
  output logic signed [mapvc_pkg::CW-1:0] y,
  output logic signed [mapvc_pkg::ZW-1:0] z
);
  import mapvc_pkg::*;

  localparam int KW = $clog2(ITERS);

  logic busy;
  logic done;
  logic rotate;
  logic [KW-1:0] k;
  logic signed [CW-1:0] x_ld, y_ld, x_next, y_next, xs, ys;
  logic signed [ZW-1:0] z_ld, z_next, at;
  logic sel;

  always_comb begin
    x_ld = x_in;
    y_ld = y_in;
    z_ld = '0;
    if (!ctl.rotate) begin
      if (x_in < 0) begin
        x_ld = -x_in;
        y_ld = -y_in;
        z_ld = (y_in >= 0) ? PI_Q28 : -PI_Q28;
      end
    end else begin
      z_ld = z_in;
      if (z_in > HALF_PI_Q28) begin
        z_ld = z_in - PI_Q28;
        x_ld = -x_in;
      end else if (z_in < -HALF_PI_Q28) begin
        z_ld = z_in + PI_Q28;
        x_ld = -x_in;
      end
    end
  end

  always_comb begin
    xs = x >>> k;
    ys = y >>> k;
    at = atan_q28(5'(k));
    sel = rotate ? !z[ZW-1] : y[CW-1];
    if (sel) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        k <= '0;
        rotate <= ctl.rotate;
        x <= x_ld;
        y <= y_ld;
        z <= z_ld;
      end else if (busy) begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        k <= k + KW'(1);
        if (k == KW'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> rtl/multi_agent_pid_velocity_controller_top.sv
// A position item for the last agent in use starts a run over the n agents in use,
// served by one shared CORDIC unit for vectoring and rotation.
// Goal items and other position items only update stored state. One item at a time.
// A run emits n results; each waits in the output register until taken.
// Reset (rst, synchronous): config to defaults, agent goal/pos/integ/prev zero.
`include "multi_agent_pid_velocity_controller_top_defines.svh"

module multi_agent_pid_velocity_controller_top #(
  parameter int MAX_AGENTS = 3,
  parameter int CORDIC_ITERS = 16
) (
  input logic clk,
  input logic rst,
  mapvc_cmd_if.sink cmd,
  mapvc_res_if.source res,
  mapvc_cfg_if.sink cfg
);
  import mapvc_pkg::*;

  localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int NW = $clog2(MAX_AGENTS + 1);
  localparam int TW = 31 + NW;

  typedef enum logic [3:0] {
    S_IDLE, S_VLOAD, S_VRUN, S_VSTORE, S_RDY, S_PLOAD, S_P1, S_P2, S_P3, S_P4,
    S_P5, S_P6, S_RLOAD, S_RRUN, S_EMIT
  } state_t;

  state_t state;
  logic [1:0] agent_count;
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [30:0] speed_limit;
  logic started;

  logic signed [31:0] goal_x [MAX_AGENTS];
  logic signed [31:0] goal_y [MAX_AGENTS];
  logic signed [31:0] pos_x [MAX_AGENTS];
  logic signed [31:0] pos_y [MAX_AGENTS];
  logic signed [47:0] integ [MAX_AGENTS];
  logic [30:0] prev [MAX_AGENTS];
  logic [30:0] dist_r [MAX_AGENTS];
  logic signed [ZW-1:0] ang_r [MAX_AGENTS];

  logic [AW-1:0] idx;
  logic [TW-1:0] total;
  logic gyl_zero;
  logic dist_sat;
  logic ready_r;
  logic signed [31:0] de_r;
  logic signed [PW-1:0] acc;
  logic signed [31:0] s_r;

  logic res_valid;
  logic [1:0] res_agent;
  logic signed [31:0] res_vx, res_vy;
  logic res_vvalid, res_rdy, res_last;

  logic [NW-1:0] n_agents;
  logic [AW-1:0] last_idx;
  logic in_use;
  logic signed [32:0] dx, dy;
  logic [30:0] dist_cur;
  logic [PW-1:0] rnd;
  logic [30:0] dist_new;
  logic signed [48:0] isum;
  logic signed [47:0] integ_new;
  logic signed [31:0] s_next;
  logic signed [PW-1:0] rot_rnd;

  cordic_ctl_t cor_ctl;
  cordic_sts_t cor_sts;
  logic signed [CW-1:0] cor_xin, cor_yin, cor_x, cor_y;
  logic signed [ZW-1:0] cor_zin, cor_z;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  function automatic logic signed [31:0] sat_cw(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > CW'(33'sh0_7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < -CW'(33'sh0_8000_0000)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    if (agent_count == 2'd0) n_agents = NW'(1);
    else if (int'(agent_count) > MAX_AGENTS) n_agents = NW'(MAX_AGENTS);
    else n_agents = NW'(agent_count);
    last_idx = AW'(n_agents - NW'(1));
    in_use = int'(cmd.agent) < int'(n_agents);
    dx = 33'(goal_x[idx]) - 33'(pos_x[idx]);
    dy = 33'(goal_y[idx]) - 33'(pos_y[idx]);
    dist_cur = dist_r[idx];
    rnd = mul_p + (PW'(1) <<< 29);
    if (dist_sat || rnd[PW-1:61] != '0) dist_new = 31'h7FFF_FFFF;
    else dist_new = rnd[60:30];
    isum = 49'(integ[idx]) + signed'({18'b0, dist_cur});
    if (isum[48] != isum[47]) integ_new = {1'b0, {47{1'b1}}};
    else integ_new = isum[47:0];
    if (acc > PW'(33'sh0_7FFF_FFFF)) s_next = 32'sh7FFF_FFFF;
    else if (acc < -PW'(33'sh0_8000_0000)) s_next = 32'sh8000_0000;
    else s_next = acc[31:0];
    if (s_next > signed'({1'b0, speed_limit})) s_next = signed'({1'b0, speed_limit});
    rot_rnd = (mul_p + (PW'(1) <<< 29)) >>> 30;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_VRUN: begin
        mul_a = signed'({1'b0, cor_x[31:0]});
        mul_b = KINV_Q30;
      end
      S_PLOAD: begin
        mul_a = MW'(gain_p);
        mul_b = signed'({2'b00, dist_cur});
      end
      S_P1: begin
        mul_a = MW'(gain_d);
        mul_b = MW'(de_r);
      end
      S_P2: begin
        mul_a = MW'(gain_i);
        mul_b = MW'(signed'(integ[idx][47:16]));
      end
      S_P3: begin
        mul_a = MW'(gain_i);
        mul_b = signed'({17'b0, integ[idx][15:0]});
      end
      S_P6: begin
        mul_a = MW'(s_r);
        mul_b = KINV_Q30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cor_ctl.start = 1'b0;
    cor_ctl.rotate = 1'b0;
    cor_xin = CW'(dx);
    cor_yin = CW'(dy);
    cor_zin = '0;
    if (state == S_VLOAD) begin
      cor_ctl.start = (dx != '0) || (dy != '0);
    end else if (state == S_RLOAD) begin
      cor_ctl.start = 1'b1;
      cor_ctl.rotate = 1'b1;
      cor_xin = CW'(rot_rnd);
      cor_yin = '0;
      cor_zin = ang_r[idx];
    end
  end

  mapvc_mul u_mul (
    .clk(clk),
    .a(mul_a),
    .b(mul_b),
    .p(mul_p)
  );

  mapvc_cordic #(
    .ITERS(CORDIC_ITERS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .ctl(cor_ctl),
    .x_in(cor_xin),
    .y_in(cor_yin),
    .z_in(cor_zin),
    .sts(cor_sts),
    .x(cor_x),
    .y(cor_y),
    .z(cor_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      agent_count <= 2'd3;
      gain_p <= 32'sd65536;
      gain_i <= '0;
      gain_d <= '0;
      speed_limit <= 31'd65536;
      started <= 1'b0;
      res_valid <= 1'b0;
      idx <= '0;
      for (int i = 0; i < MAX_AGENTS; i++) begin
        goal_x[i] <= '0;
        goal_y[i] <= '0;
        pos_x[i] <= '0;
        pos_y[i] <= '0;
        integ[i] <= '0;
        prev[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          REG_AGENT_COUNT: agent_count <= cfg.data[1:0];
          REG_GAIN_P: gain_p <= signed'(cfg.data);
          REG_GAIN_I: gain_i <= signed'(cfg.data);
          REG_GAIN_D: gain_d <= signed'(cfg.data);
          REG_SPEED_LIMIT: speed_limit <= cfg.data[30:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid && in_use) begin
            if (cmd.action == ACT_GOAL) begin
              goal_x[AW'(cmd.agent)] <= cmd.x_coord;
              goal_y[AW'(cmd.agent)] <= cmd.y_coord;
              started <= 1'b1;
            end else begin
              pos_x[AW'(cmd.agent)] <= cmd.x_coord;
              pos_y[AW'(cmd.agent)] <= cmd.y_coord;
              if (AW'(cmd.agent) == last_idx) begin
                idx <= '0;
                total <= '0;
                state <= S_VLOAD;
              end
            end
          end
        end
        S_VLOAD: begin
          if (idx == last_idx) gyl_zero <= (goal_y[idx] == '0);
          if (cor_ctl.start) begin
            state <= S_VRUN;
          end else begin
            dist_r[idx] <= '0;
            ang_r[idx] <= '0;
            if (idx == last_idx) begin
              state <= S_RDY;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_VRUN: begin
          if (cor_sts.done) begin
            dist_sat <= (cor_x[CW-1:32] != '0);
            state <= S_VSTORE;
          end
        end
        S_VSTORE: begin
          dist_r[idx] <= dist_new;
          ang_r[idx] <= cor_z;
          total <= total + TW'(dist_new);
          if (idx == last_idx) begin
            state <= S_RDY;
          end else begin
            idx <= idx + AW'(1);
            state <= S_VLOAD;
          end
        end
        S_RDY: begin
          ready_r <= (total < TW'(READY_THRESH)) || ((goal_x[0] == '0) && gyl_zero);
          idx <= '0;
          state <= S_PLOAD;
        end
        S_PLOAD: begin
          if (started) begin
            integ[idx] <= integ_new;
            de_r <= signed'({1'b0, dist_cur}) - signed'({1'b0, prev[idx]});
            prev[idx] <= dist_cur;
            state <= S_P1;
          end else begin
            res_vx <= '0;
            res_vy <= '0;
            res_valid <= 1'b1;
            res_agent <= 2'(idx);
            res_vvalid <= 1'b0;
            res_rdy <= ready_r;
            res_last <= (idx == last_idx);
            state <= S_EMIT;
          end
        end
        S_P1: begin
          acc <= mul_p >>> 16;
          state <= S_P2;
        end
        S_P2: begin
          acc <= acc + (mul_p >>> 16);
          state <= S_P3;
        end
        S_P3: begin
          acc <= acc + mul_p;
          state <= S_P4;
        end
        S_P4: begin
          acc <= acc + (mul_p >>> 16);
          state <= S_P5;
        end
        S_P5: begin
          s_r <= s_next;
          state <= S_P6;
        end
        S_P6: begin
          state <= S_RLOAD;
        end
        S_RLOAD: begin
          state <= S_RRUN;
        end
        S_RRUN: begin
          if (cor_sts.done) begin
            res_vx <= sat_cw(cor_x);
            res_vy <= sat_cw(cor_y);
            res_valid <= 1'b1;
            res_agent <= 2'(idx);
            res_vvalid <= 1'b1;
            res_rdy <= ready_r;
            res_last <= (idx == last_idx);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res.ready) begin
            res_valid <= 1'b0;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + AW'(1);
              state <= S_PLOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.agent_out = res_agent;
  assign res.vel_x = res_vx;
  assign res.vel_y = res_vy;
  assign res.vel_valid = res_vvalid;
  assign res.ready_res = res_rdy;
  assign res.last = res_last;

  `MAPVC_ASSERT_IMP(a_idle_no_result, cmd.ready, !res_valid)
  `MAPVC_ASSERT_NXT(a_last_to_idle, res_valid && res.ready && res_last, state == S_IDLE)
  `MAPVC_ASSERT_IMP(a_cordic_free, cor_ctl.start, !cor_sts.busy)

endmodule
